// ----- rtl/core/pspl_pkg.sv -----
// Package for the per-source packet limiter: sizes, register addresses,
// and the item and configuration structs shared by the front, queue, back and top files.
package pspl_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int COUNT_WIDTH   = 16;
  localparam int PORT_W        = 16;
  localparam int CYCLE_W       = 48;
  localparam int LIMIT_W       = 16;
  localparam int CMP_W         = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam int PADDR_W       = 5;
  localparam int PDATA_W       = 64;

  // register index, taken from paddr[4:3]
  localparam logic [1:0] REG_READY = 2'd0;
  localparam logic [1:0] REG_CYCLE = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

  localparam logic [LIMIT_W-1:0]     LIMIT_RESET = LIMIT_W'(2);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX   = {COUNT_WIDTH{1'b1}};
  localparam logic [COUNT_WIDTH-1:0] COUNT_ONE   = COUNT_WIDTH'(1);

  typedef struct packed {
    logic               receiver_ready;
    logic [CYCLE_W-1:0] current_cycle;
    logic [LIMIT_W-1:0] packet_limit;
  } cfg_t;

  typedef struct packed {
    logic [PORT_W-1:0] source_port;
    logic              drop_all;
  } item_t;

endpackage

// ----- rtl/core/pspl_ifs.sv -----
// Valid/ready channel interfaces of the packet limiter.
// Depends on pspl_pkg for field widths.
interface pspl_in_if;
  logic                        valid;
  logic                        ready;
  logic [pspl_pkg::PORT_W-1:0] source_port;
  modport source (output valid, output source_port, input ready);
  modport sink   (input valid, input source_port, output ready);
endinterface

interface pspl_out_if;
  logic valid;
  logic ready;
  logic pass;
  modport source (output valid, output pass, input ready);
  modport sink   (input valid, input pass, output ready);
endinterface

// ----- rtl/core/pspl_front.sv -----
// Front stage: accepts packets, tags those arriving while the receiver is
// not ready, and hands them to the queue. Depends on pspl_pkg.
module pspl_front (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pspl_pkg::PORT_W-1:0] in_port,
  input  pspl_pkg::cfg_t              cfg,
  output logic                        push_valid,
  input  logic                        push_ready,
  output pspl_pkg::item_t             push_item
);

  logic            stage_valid;
  pspl_pkg::item_t stage_item;

  assign in_ready   = !stage_valid || push_ready;
  assign push_valid = stage_valid;
  assign push_item  = stage_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  // classify on accept: a receiver that is not ready means drop without a table update
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item.source_port <= in_port;
      stage_item.drop_all    <= !cfg.receiver_ready;
    end
  end

endmodule

// ----- rtl/core/pspl_queue.sv -----
// Short FIFO between the front and back stages.
// Depends on pspl_pkg for depth and item type.
module pspl_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  pspl_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output pspl_pkg::item_t pop_item
);

  pspl_pkg::item_t                 slots [pspl_pkg::QUEUE_DEPTH];
  logic [pspl_pkg::QPTR_W-1:0]     wr_ptr;
  logic [pspl_pkg::QPTR_W-1:0]     rd_ptr;
  logic [pspl_pkg::QCNT_W-1:0]     fill;
  logic                            do_push;
  logic                            do_pop;

  assign push_ready = fill != pspl_pkg::QCNT_W'(pspl_pkg::QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  function automatic logic [pspl_pkg::QPTR_W-1:0] bump(input logic [pspl_pkg::QPTR_W-1:0] p);
    bump = (p == pspl_pkg::QPTR_W'(pspl_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop)  rd_ptr <= bump(rd_ptr);
      if (do_push && !do_pop)      fill <= fill + 1'b1;
      else if (!do_push && do_pop) fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_item;
  end

endmodule

// ----- rtl/core/pspl_back.sv -----
// Back stage: source table, pass/drop decision and the output register.
// Depends on pspl_pkg for table sizes, item and configuration types.
module pspl_back (
  input  logic            clk,
  input  logic            rst,
  input  pspl_pkg::cfg_t  cfg,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  pspl_pkg::item_t pop_item,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_pass
);

  localparam int N = pspl_pkg::TABLE_ENTRIES;

  logic [N-1:0]                        entry_valid;
  logic [pspl_pkg::PORT_W-1:0]         entry_port  [N];
  logic [pspl_pkg::CYCLE_W-1:0]        entry_cycle [N];
  logic [pspl_pkg::COUNT_WIDTH-1:0]    entry_count [N];

  logic [N-1:0]                        match;
  logic [N-1:0]                        hit_oh;
  logic [N-1:0]                        free_oh;
  logic [pspl_pkg::CYCLE_W-1:0]        sel_cycle;
  logic [pspl_pkg::COUNT_WIDTH-1:0]    sel_count;
  logic                                hit_any;
  logic                                stale;
  logic                                at_limit;
  logic [N-1:0]                        fresh_oh;
  logic [N-1:0]                        inc_oh;
  logic                                pass_next;
  logic                                take;

  assign pop_ready = !out_valid || out_ready;
  assign take      = pop_valid && pop_ready;

  always_comb begin
    sel_cycle = '0;
    sel_count = '0;
    for (int i = 0; i < N; i++) begin
      match[i] = entry_valid[i] && (entry_port[i] == pop_item.source_port);
    end
    // keep the lowest set bit
    hit_oh  = match & (~match + 1'b1);
    free_oh = ~entry_valid & (entry_valid + 1'b1);
    for (int i = 0; i < N; i++) begin
      if (hit_oh[i]) begin
        sel_cycle = sel_cycle | entry_cycle[i];
        sel_count = sel_count | entry_count[i];
      end
    end
    hit_any  = |match;
    stale    = sel_cycle != cfg.current_cycle;
    at_limit = pspl_pkg::CMP_W'(sel_count) >= pspl_pkg::CMP_W'(cfg.packet_limit);

    fresh_oh  = '0;
    inc_oh    = '0;
    pass_next = 1'b0;
    if (!pop_item.drop_all) begin
      if (!hit_any) begin
        fresh_oh  = free_oh;
        pass_next = 1'b1;
      end else if (stale) begin
        fresh_oh  = hit_oh;
        pass_next = 1'b1;
      end else if (!at_limit) begin
        // hold the count at its top value once saturated
        if (sel_count != pspl_pkg::COUNT_MAX) inc_oh = hit_oh;
        pass_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (take) begin
      entry_valid <= entry_valid | fresh_oh;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (take && fresh_oh[i]) begin
        entry_port[i]  <= pop_item.source_port;
        entry_cycle[i] <= cfg.current_cycle;
        entry_count[i] <= pspl_pkg::COUNT_ONE;
      end else if (take && inc_oh[i]) begin
        entry_count[i] <= entry_count[i] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_ready) begin
      out_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) out_pass <= pass_next;
  end

endmodule

// ----- rtl/core/per_source_packet_limiter.sv -----
// Top level of the per-source packet limiter: APB register file, front,
// queue and back stages. Depends on pspl_pkg, pspl_ifs and the stage modules.
//
//   channel   dir   payload            handshake
//   pkt_in    in    source_port[15:0]  valid/ready
//   verdict   out   pass               valid/ready
//   apb       in    64-bit regs 0/8/16 psel/penable, pready tied high
//
// One packet per cycle sustained while verdicts are taken; a verdict passes
// through the front register, a queue slot and the output register after its
// packet is accepted. The rate rests on the back stage, which compares all
// table entries combinationally and updates the chosen one as it takes a packet.
// Reset clears the table valid bits and the registers at once.
// A stalled verdict holds in the output register; the queue and front
// stage keep accepting until they fill.
module per_source_packet_limiter (
  input  logic                          clk,
  input  logic                          rst,
  pspl_in_if.sink                       pkt_in,
  pspl_out_if.source                    verdict,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pspl_pkg::PADDR_W-1:0]  paddr,
  input  logic [pspl_pkg::PDATA_W-1:0]  pwdata,
  output logic [pspl_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  pspl_pkg::cfg_t  cfg;
  logic            push_valid;
  logic            push_ready;
  pspl_pkg::item_t push_item;
  logic            pop_valid;
  logic            pop_ready;
  pspl_pkg::item_t pop_item;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.receiver_ready <= 1'b0;
      cfg.current_cycle  <= '0;
      cfg.packet_limit   <= pspl_pkg::LIMIT_RESET;
    end else if (wr_en) begin
      case (paddr[4:3])
        pspl_pkg::REG_READY: cfg.receiver_ready <= pwdata[0];
        pspl_pkg::REG_CYCLE: cfg.current_cycle  <= pwdata[pspl_pkg::CYCLE_W-1:0];
        pspl_pkg::REG_LIMIT: cfg.packet_limit   <= pwdata[pspl_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      pspl_pkg::REG_READY: prdata = pspl_pkg::PDATA_W'(cfg.receiver_ready);
      pspl_pkg::REG_CYCLE: prdata = pspl_pkg::PDATA_W'(cfg.current_cycle);
      pspl_pkg::REG_LIMIT: prdata = pspl_pkg::PDATA_W'(cfg.packet_limit);
      default:             prdata = '0;
    endcase
  end

  pspl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (pkt_in.valid),
    .in_ready   (pkt_in.ready),
    .in_port    (pkt_in.source_port),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  pspl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  pspl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item),
    .out_valid  (verdict.valid),
    .out_ready  (verdict.ready),
    .out_pass   (verdict.pass)
  );

endmodule

// ----- rtl/core/pspl_checker.sv -----
// Port-level checks for the packet limiter, bound to the top level.
// Depends on pspl_pkg for address and data widths.
module pspl_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         pass,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [pspl_pkg::PADDR_W-1:0] paddr,
  input logic [pspl_pkg::PDATA_W-1:0] pwdata,
  input logic [pspl_pkg::PDATA_W-1:0] prdata
);

  logic wr;
  assign wr = psel && penable && pwrite;

  // hold a stalled verdict
  a_verdict_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pass))
    else $error("verdict changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("verdict valid right after reset");

  a_limit_readback: assert property (@(posedge clk) disable iff (rst)
    (wr && paddr[4:3] == pspl_pkg::REG_LIMIT) ##1
    (psel && !pwrite && paddr[4:3] == pspl_pkg::REG_LIMIT)
    |-> prdata == pspl_pkg::PDATA_W'($past(pwdata[pspl_pkg::LIMIT_W-1:0])))
    else $error("packet limit readback mismatch");

  a_ready_readback: assert property (@(posedge clk) disable iff (rst)
    (wr && paddr[4:3] == pspl_pkg::REG_READY) ##1
    (psel && !pwrite && paddr[4:3] == pspl_pkg::REG_READY)
    |-> prdata == pspl_pkg::PDATA_W'($past(pwdata[0])))
    else $error("receiver ready readback mismatch");

endmodule

bind per_source_packet_limiter pspl_checker u_pspl_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (verdict.valid),
  .out_ready (verdict.ready),
  .pass      (verdict.pass),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
